FILE: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and constants for the segment tree sum/count core
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int LEAVES_DEF = 1024;

    localparam int SUM_W = 42;
    localparam int CNT_W = 11;
    localparam int POS_W = 10;
    localparam int VAL_W = 32;
    localparam int RNG_W = 11;

    // request action codes
    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // one tree node: sum of leaf values and count of set leaves below it
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } node_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        acc_op_t op;
        node_t   operand;
    } acc_ctrl_t;

endpackage

FILE: sv/segment_tree_sum_count_core.sv
// ----------------------------------------------------------------------------
// segment_tree_sum_count_core
// segment tree over LEAVES leaves keeping range sums and set-leaf counts;
// point update and half-open range query
// ----------------------------------------------------------------------------
//  channel | handshake            | beat contents
//  req     | req_valid/req_stall  | action, position, leaf_value,
//          |                      | range_start, range_end
//  rsp     | rsp_valid/rsp_stall  | range_sum, range_count (queries only)
//
// one node memory access per cycle through a single adder sets the pace, P being
// LEAVES rounded up to a power of two; one beat is in work at a time
// update: leaf write, then a sibling read and a parent write per level up to the root
// query: a lo step and a hi step per level walked, then a done state that waits
// only while the response register is full and stalled; req_stall high throughout
// after reset a clearing pass writes all 2*P node slots, req_stall high
// ----------------------------------------------------------------------------
module segment_tree_sum_count_core #(
    parameter int LEAVES = sts_pkg::LEAVES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         action,
    input  logic [sts_pkg::POS_W-1:0]    position,
    input  logic [sts_pkg::VAL_W-1:0]    leaf_value,
    input  logic [sts_pkg::RNG_W-1:0]    range_start,
    input  logic [sts_pkg::RNG_W-1:0]    range_end,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [sts_pkg::SUM_W-1:0]    range_sum,
    output logic [sts_pkg::CNT_W-1:0]    range_count
);
    import sts_pkg::*;

    localparam int AW = $clog2(LEAVES) + 1;

    logic            done;
    logic            out_free;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    node_t           mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    node_t           mem_rdata;
    acc_ctrl_t       acc_ctrl;
    node_t           acc_value;
    node_t           acc_total;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [SUM_W-1:0]   rsp_sum_reg;
    logic [CNT_W-1:0]   rsp_count_reg;

    sts_seq #(
        .LEAVES (LEAVES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .action      (action),
        .position    (position),
        .leaf_value  (leaf_value),
        .range_start (range_start),
        .range_end   (range_end),
        .out_free    (out_free),
        .done        (done),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .acc_ctrl    (acc_ctrl),
        .acc_total   (acc_total)
    );

    sts_mem #(
        .AW (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sts_acc u_acc (
        .clk   (clk),
        .ctrl  (acc_ctrl),
        .rdata (mem_rdata),
        .acc   (acc_value),
        .total (acc_total)
    );

    // response register frees up when its beat is taken
    assign out_free       = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next = done || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_sum_reg   <= acc_value.sum;
            rsp_count_reg <= acc_value.cnt;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign range_sum   = rsp_sum_reg;
    assign range_count = rsp_count_reg;

endmodule

FILE: sv/sts_mem.sv
// ----------------------------------------------------------------------------
// sts_mem
// node memory in heap order, one write and one read port, registered read
// ----------------------------------------------------------------------------
module sts_mem #(
    parameter int AW = 11
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  sts_pkg::node_t  wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output sts_pkg::node_t  rdata
);
    import sts_pkg::*;

    localparam int DEPTH = 2 ** AW;

    node_t mem_array [DEPTH];
    node_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/sts_acc.sv
// ----------------------------------------------------------------------------
// sts_acc
// shared node adder with accumulator, used by both the update path walk and
// the range query walk
// ----------------------------------------------------------------------------
module sts_acc (
    input  logic               clk,
    input  sts_pkg::acc_ctrl_t ctrl,
    input  sts_pkg::node_t     rdata,
    output sts_pkg::node_t     acc,
    output sts_pkg::node_t     total
);
    import sts_pkg::*;

    node_t acc_reg;
    node_t acc_next;

    // sums wrap at the node widths
    always_comb
    begin
        total.sum = acc_reg.sum + rdata.sum;
        total.cnt = acc_reg.cnt + rdata.cnt;
    end

    always_comb
    begin
        case (ctrl.op)
            ACC_CLEAR: acc_next = '0;
            ACC_LOAD:  acc_next = ctrl.operand;
            ACC_ADD:   acc_next = total;
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: sv/sts_seq.sv
// ----------------------------------------------------------------------------
// sts_seq
// sequencer: clearing pass after reset, leaf update with path walk to the
// root, and bottom-up range query walk
// ----------------------------------------------------------------------------
module sts_seq #(
    parameter int LEAVES = sts_pkg::LEAVES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic                             action,
    input  logic [sts_pkg::POS_W-1:0]        position,
    input  logic [sts_pkg::VAL_W-1:0]        leaf_value,
    input  logic [sts_pkg::RNG_W-1:0]        range_start,
    input  logic [sts_pkg::RNG_W-1:0]        range_end,
    input  logic                             out_free,
    output logic                             done,
    output logic                             mem_we,
    output logic [$clog2(LEAVES)+1-1:0]      mem_waddr,
    output sts_pkg::node_t                   mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(LEAVES)+1-1:0]      mem_raddr,
    output sts_pkg::acc_ctrl_t               acc_ctrl,
    input  sts_pkg::node_t                   acc_total
);
    import sts_pkg::*;

    localparam int LG = $clog2(LEAVES);
    localparam int P  = 1 << LG;
    localparam int AW = LG + 1;
    localparam int NW = AW + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_Q_LO,
        S_Q_HI,
        S_Q_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [AW-1:0]   node_reg, node_next;
    logic [NW-1:0]   lo_reg, lo_next;
    logic [NW-1:0]   hi_reg, hi_next;
    logic            pend_reg, pend_next;

    logic [NW-1:0]   hi_clamp;
    logic [NW-1:0]   lo_clamp;
    logic [AW-1:0]   leaf_node;
    logic [NW-1:0]   lo_dec;
    logic [NW-1:0]   hi_dec2;
    logic            req_fire;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && (state_reg == S_IDLE);

    always_comb
    begin
        if (32'(range_end) > 32'(LEAVES))
        begin
            hi_clamp = NW'(LEAVES);
        end
        else
        begin
            hi_clamp = NW'(range_end);
        end
        // an empty range starts with lo equal to hi
        if (32'(range_start) >= 32'(hi_clamp))
        begin
            lo_clamp = hi_clamp;
        end
        else
        begin
            lo_clamp = NW'(range_start);
        end
    end

    assign leaf_node = AW'(32'(position) + 32'(P));
    assign lo_dec    = lo_reg - NW'(1);
    assign hi_dec2   = hi_reg - NW'(2);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        node_next  = node_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pend_next  = pend_reg;
        done       = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        acc_ctrl   = '{op: ACC_HOLD, operand: '0};

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (action == ACT_SET)
                    begin
                        if (32'(position) < 32'(LEAVES))
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = leaf_node - AW'(1);
                            mem_wdata.sum       = SUM_W'(leaf_value);
                            mem_wdata.cnt       = CNT_W'(1);
                            acc_ctrl.op         = ACC_LOAD;
                            acc_ctrl.operand    = mem_wdata;
                            node_next           = leaf_node;
                            state_next          = S_UP_RD;
                        end
                    end
                    else
                    begin
                        acc_ctrl.op = ACC_CLEAR;
                        lo_next     = lo_clamp + NW'(P);
                        hi_next     = hi_clamp + NW'(P);
                        pend_next   = 1'b0;
                        state_next  = S_Q_LO;
                    end
                end
            end

            // fetch the sibling of the current path node
            S_UP_RD:
            begin
                if (node_reg == AW'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = (node_reg ^ AW'(1)) - AW'(1);
                    state_next = S_UP_WR;
                end
            end

            // parent = path node + sibling
            S_UP_WR:
            begin
                acc_ctrl.op = ACC_ADD;
                mem_we      = 1'b1;
                mem_waddr   = (node_reg >> 1) - AW'(1);
                mem_wdata   = acc_total;
                node_next   = node_reg >> 1;
                state_next  = S_UP_RD;
            end

            S_Q_LO:
            begin
                if (pend_reg)
                begin
                    acc_ctrl.op = ACC_ADD;
                end
                if (lo_reg < hi_reg)
                begin
                    if (lo_reg[0])
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = lo_dec[AW-1:0];
                        lo_next   = lo_reg + NW'(1);
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                    state_next = S_Q_HI;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_Q_DONE;
                end
            end

            S_Q_HI:
            begin
                if (pend_reg)
                begin
                    acc_ctrl.op = ACC_ADD;
                end
                if (hi_reg[0])
                begin
                    mem_re    = 1'b1;
                    mem_raddr = hi_dec2[AW-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // odd hi is decremented first, same result after the shift
                lo_next    = lo_reg >> 1;
                hi_next    = hi_reg >> 1;
                state_next = S_Q_LO;
            end

            S_Q_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            node_reg  <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            node_reg  <= node_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            pend_reg  <= pend_next;
        end
    end

endmodule
